[rtl/kfsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe segment interpolator package
// Shared widths, field codes, the segment record type and the scan control type.
// ----------------------------------------------------------------------------
package kfsi_pkg;

  localparam int unsigned MaxSegmentsDefault = 16;
  localparam int unsigned RateW  = 24;
  localparam int unsigned ValW   = 32;
  localparam int unsigned DiffW  = ValW + 1;
  localparam int unsigned ProdW  = ValW + RateW;
  localparam int unsigned CountW = 5;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned InDataW  = 272;
  localparam int unsigned OutDataW = 96;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic [RateW-1:0]  rate_start;
    logic [RateW-1:0]  rate_end;
    logic [ValW-1:0]   start_x;
    logic [ValW-1:0]   start_y;
    logic [ValW-1:0]   start_z;
    logic [ValW-1:0]   end_x;
    logic [ValW-1:0]   end_y;
    logic [ValW-1:0]   end_z;
  } seg_t;

  // Control passed along the cell row while a query travels through it.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [RateW-1:0] rate;
  } scan_t;

endpackage

[rtl/kfsi_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe segment cell
// Holds one segment; passes the query token and the first hit down the row.
// ----------------------------------------------------------------------------
module kfsi_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [7:0]            load_idx_i,
  input  kfsi_pkg::seg_t        load_seg_i,
  input  logic [CntW-1:0]       in_use_i,
  input  kfsi_pkg::scan_t       scan_i,
  input  kfsi_pkg::seg_t        hit_seg_i,
  output kfsi_pkg::scan_t       scan_o,
  output kfsi_pkg::seg_t        hit_seg_o
);
  import kfsi_pkg::*;

  seg_t  seg_q;
  scan_t scan_q, scan_d;
  seg_t  hit_q, hit_d;
  logic  match;

  always_ff @(posedge clk_i) begin
    if (load_i && load_idx_i == 8'(Index)) begin
      seg_q <= load_seg_i;
    end
  end

  // A cell matches only inside the in-use count; it takes the hit only if no earlier hit.
  assign match = (32'(Index) < 32'(in_use_i)) && (seg_q.rate_start <= scan_i.rate)
                 && (scan_i.rate < seg_q.rate_end);

  always_comb begin
    scan_d = scan_i;
    hit_d  = hit_seg_i;
    if (scan_i.valid && !scan_i.hit && match) begin
      scan_d.hit = 1'b1;
      hit_d      = seg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign scan_o    = scan_q;
  assign hit_seg_o = hit_q;

endmodule

[rtl/kfsi_lerp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe lerp unit
// One lane at a time: multiply, then restoring division one bit a cycle.
// ----------------------------------------------------------------------------
module kfsi_lerp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  kfsi_pkg::seg_t              seg_i,
  input  logic [kfsi_pkg::RateW-1:0]  rate_i,
  output logic                        done_o,
  output logic [3*kfsi_pkg::ValW-1:0] result_o
);
  import kfsi_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StAdd  = 3'd4;

  logic [2:0]       st_q, st_d;
  logic [1:0]       lane_q, lane_d;
  logic [5:0]       bit_q, bit_d;
  seg_t             seg_q;
  logic [RateW-1:0] off_q, span_q;
  logic             neg_q;
  logic [ValW-1:0]  s_q, e_q, base_q;
  logic [ProdW-1:0] num_q;
  logic [RateW:0]   rem_q;
  logic [3*ValW-1:0] res_q;
  logic             done_q;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0] mag;
  logic [RateW+1:0] trial;
  logic [ValW-1:0]  lane_res;

  assign diff  = DiffW'($signed(e_q)) - DiffW'($signed(s_q));
  assign mag   = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign trial = {rem_q, num_q[ProdW-1]} - {2'b0, span_q};
  assign lane_res = neg_q ? base_q - num_q[ValW-1:0] : base_q + num_q[ValW-1:0];

  always_comb begin
    st_d = st_q;
    lane_d = lane_q;
    bit_d = bit_q;
    case (st_q)
      StIdle: if (start_i) begin
        st_d = StPrep;
        lane_d = '0;
      end
      StPrep: st_d = StMul;
      StMul: begin
        st_d = StDiv;
        bit_d = 6'(ProdW - 1);
      end
      StDiv: if (bit_q == '0) st_d = StAdd;
      else bit_d = bit_q - 6'd1;
      StAdd: begin
        if (lane_q == 2'd2) st_d = StIdle;
        else begin
          st_d = StPrep;
          lane_d = lane_q + 2'd1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      lane_q <= '0;
      bit_q <= '0;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      lane_q <= lane_d;
      bit_q <= bit_d;
      done_q <= (st_q == StAdd) && (lane_q == 2'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (start_i) begin
        seg_q  <= seg_i;
        off_q  <= rate_i - seg_i.rate_start;
        span_q <= seg_i.rate_end - seg_i.rate_start;
      end
      StPrep: begin
        case (lane_q)
          2'd0: begin s_q <= seg_q.start_x; e_q <= seg_q.end_x; end
          2'd1: begin s_q <= seg_q.start_y; e_q <= seg_q.end_y; end
          default: begin s_q <= seg_q.start_z; e_q <= seg_q.end_z; end
        endcase
      end
      StMul: begin
        neg_q  <= diff[DiffW-1];
        base_q <= s_q;
        rem_q  <= '0;
        // The product is shifted out MSB first, one quotient bit per cycle.
        num_q  <= ProdW'(mag) * ProdW'(off_q);
      end
      StDiv: begin
        if (!trial[RateW+1]) begin
          rem_q <= trial[RateW:0];
          num_q <= {num_q[ProdW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[RateW-1:0], num_q[ProdW-1]};
          num_q <= {num_q[ProdW-2:0], 1'b0};
        end
      end
      StAdd: begin
        res_q[32'(lane_q)*ValW +: ValW] <= lane_res;
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[rtl/keyframe_segment_interpolator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe segment interpolator
// Piecewise linear interpolation over a table of keyframe segments.
// ----------------------------------------------------------------------------
// A load transaction's result is offered in the cycle after its acceptance.
// A query walks the cell row, then for a hit passes lane by lane through
// the shared multiply and bit-serial divide unit.
// One item is in flight at a time; the next is accepted only after the
// result has left, so a result waiting on m_axis_tready holds the input off.
// Reset clears the control state and segments_in_use; segment cells hold
// undefined contents until loaded.
module keyframe_segment_interpolator_unit #(
  parameter int unsigned MAX_SEGMENTS = kfsi_pkg::MaxSegmentsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kfsi_pkg::CountW-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata from bit 0: entry_index, rate_start, rate_end, start_x, start_y,
  // start_z, end_x, end_y, end_z, query_rate.
  input  logic [kfsi_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: func.
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata from bit 0: out_x, out_y, out_z.
  output logic [kfsi_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: found.
  output logic                          m_axis_tuser
);
  import kfsi_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StCalc = 2'd2;

  logic [1:0] st_q, st_d;
  logic [CountW-1:0] in_use_q;
  logic out_valid_q, found_q;
  logic [OutDataW-1:0] out_data_q;
  logic accept, load;
  logic [IdxW-1:0] idx;
  seg_t load_seg;
  scan_t scan_in;
  scan_t chain_scan [MAX_SEGMENTS+1];
  seg_t  chain_seg  [MAX_SEGMENTS+1];
  logic lerp_done;
  logic [3*ValW-1:0] lerp_res;
  logic lerp_start;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == StIdle) && !out_valid_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign load   = accept && (s_axis_tuser == FuncLoad);
  assign idx    = s_axis_tdata[IdxW-1:0];

  assign load_seg.rate_start = s_axis_tdata[4 +: RateW];
  assign load_seg.rate_end   = s_axis_tdata[28 +: RateW];
  assign load_seg.start_x    = s_axis_tdata[52 +: ValW];
  assign load_seg.start_y    = s_axis_tdata[84 +: ValW];
  assign load_seg.start_z    = s_axis_tdata[116 +: ValW];
  assign load_seg.end_x      = s_axis_tdata[148 +: ValW];
  assign load_seg.end_y      = s_axis_tdata[180 +: ValW];
  assign load_seg.end_z      = s_axis_tdata[212 +: ValW];

  // The query token enters the row at cell 0 and walks one cell per cycle.
  assign scan_in.valid = accept && (s_axis_tuser == FuncQuery);
  assign scan_in.hit   = 1'b0;
  assign scan_in.rate  = s_axis_tdata[244 +: RateW];
  assign chain_scan[0] = scan_in;
  assign chain_seg[0]  = load_seg;

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    kfsi_cell #(.Index(g), .CntW(CountW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (load),
      .load_idx_i (8'(idx)),
      .load_seg_i (load_seg),
      .in_use_i   (in_use_q),
      .scan_i     (chain_scan[g]),
      .hit_seg_i  (chain_seg[g]),
      .scan_o     (chain_scan[g+1]),
      .hit_seg_o  (chain_seg[g+1])
    );
  end

  assign lerp_start = (st_q == StScan) && chain_scan[MAX_SEGMENTS].valid
                      && chain_scan[MAX_SEGMENTS].hit;

  kfsi_lerp u_lerp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lerp_start),
    .seg_i    (chain_seg[MAX_SEGMENTS]),
    .rate_i   (chain_scan[MAX_SEGMENTS].rate),
    .done_o   (lerp_done),
    .result_o (lerp_res)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (scan_in.valid) st_d = StScan;
      StScan: if (chain_scan[MAX_SEGMENTS].valid) begin
        st_d = chain_scan[MAX_SEGMENTS].hit ? StCalc : StIdle;
      end
      StCalc: if (lerp_done) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      in_use_q <= '0;
      out_valid_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) in_use_q <= cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      if (load) begin
        out_valid_q <= 1'b1;
        found_q <= 1'b0;
      end else if (st_q == StScan && chain_scan[MAX_SEGMENTS].valid
                   && !chain_scan[MAX_SEGMENTS].hit) begin
        out_valid_q <= 1'b1;
        found_q <= 1'b0;
      end else if (st_q == StCalc && lerp_done) begin
        out_valid_q <= 1'b1;
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load || (st_q == StScan && chain_scan[MAX_SEGMENTS].valid
                 && !chain_scan[MAX_SEGMENTS].hit)) begin
      out_data_q <= '0;
    end else if (st_q == StCalc && lerp_done) begin
      out_data_q <= lerp_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = found_q;

  // No item is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !s_axis_tready) else $error("accept while result pending");
  // A finished lerp only happens in the compute state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lerp_done |-> st_q == StCalc) else $error("stray lerp completion");
  // A query leaves idle for the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_in.valid |=> st_q == StScan) else $error("query not scanned");

endmodule

[tb/tb_keyframe_segment_interpolator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe segment interpolator testbench
// Drives loads and queries into the interpolator, runs an in-bench predictor
// of the segment table and the per-lane interpolation, and compares every
// result transaction against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_keyframe_segment_interpolator_unit;
  import kfsi_pkg::*;

  localparam int unsigned NumSeg   = MaxSegmentsDefault;
  localparam int unsigned WdogMax  = 20000;
  localparam int unsigned DrainCyc = 400;

  // One input transaction as the bench sees it.
  typedef struct {
    logic             func;
    logic [IdxW-1:0]  slot;
    seg_t             seg;
    logic [RateW-1:0] qrate;
  } item_t;

  // One predicted result transaction.
  typedef struct {
    logic            found;
    logic [ValW-1:0] x;
    logic [ValW-1:0] y;
    logic [ValW-1:0] z;
  } lerp_res_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CountW-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;

  keyframe_segment_interpolator_unit #(.MAX_SEGMENTS(NumSeg)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predictor state: a shadow of the segment table and the search count.
  seg_t             shadow_seg [NumSeg];
  logic [CountW-1:0] shadow_count;
  // Which slots have been loaded; the stimulus never searches past these.
  bit               slot_loaded [NumSeg];

  item_t     pending_items [$];
  lerp_res_t expected_results [$];

  int unsigned err_count;
  int unsigned idle_cycles;
  // Set by the stimulus to force a long receiver hold-off.
  bit          hold_request;
  int unsigned hold_left;
  // Input handshake seen at the last rising edge.
  bit          in_fire;

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one, and runs with none at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // start + (end - start) * off / span, quotient truncated toward zero.
  function automatic logic [ValW-1:0] lerp_lane(logic [ValW-1:0] s_bits,
                                               logic [ValW-1:0] e_bits,
                                               logic [RateW-1:0] off,
                                               logic [RateW-1:0] span);
    logic signed [DiffW-1:0] diff;
    logic [DiffW-1:0]        mag;
    logic [63:0]             quot;
    logic signed [63:0]      sum;
    diff = $signed({e_bits[ValW-1], e_bits}) - $signed({s_bits[ValW-1], s_bits});
    mag  = diff[DiffW-1] ? -diff : diff;
    quot = (64'(mag) * 64'(off)) / 64'(span);
    sum  = diff[DiffW-1] ? $signed(64'(signed'(s_bits))) - $signed(quot)
                         : $signed(64'(signed'(s_bits))) + $signed(quot);
    return sum[ValW-1:0];
  endfunction

  // Updates the shadow table for a load and returns the result the item causes.
  function automatic lerp_res_t predict_interp(item_t it);
    lerp_res_t   res;
    int unsigned n;
    res = '{found: 1'b0, x: '0, y: '0, z: '0};
    if (it.func == FuncLoad) begin
      shadow_seg[it.slot] = it.seg;
      return res;
    end
    n = (shadow_count > NumSeg) ? NumSeg : shadow_count;
    for (int unsigned i = 0; i < n; i++) begin
      seg_t s;
      s = shadow_seg[i];
      if (s.rate_start <= it.qrate && it.qrate < s.rate_end) begin
        res.found = 1'b1;
        res.x = lerp_lane(s.start_x, s.end_x, it.qrate - s.rate_start,
                          s.rate_end - s.rate_start);
        res.y = lerp_lane(s.start_y, s.end_y, it.qrate - s.rate_start,
                          s.rate_end - s.rate_start);
        res.z = lerp_lane(s.start_z, s.end_z, it.qrate - s.rate_start,
                          s.rate_end - s.rate_start);
        break;
      end
    end
    return res;
  endfunction

  function automatic logic [ValW-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [RateW-1:0] rand_rate();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return RateW'($urandom_range(0, 600));
      default: return RateW'($urandom);
    endcase
  endfunction

  task automatic push_load(int unsigned slot, logic [RateW-1:0] rs,
                           logic [RateW-1:0] re);
    item_t it;
    it.func  = FuncLoad;
    it.slot  = IdxW'(slot);
    it.seg   = '{rate_start: rs, rate_end: re,
                 start_x: rand_val(), start_y: rand_val(), start_z: rand_val(),
                 end_x: rand_val(), end_y: rand_val(), end_z: rand_val()};
    // A load carries noise in the unused query field.
    it.qrate = RateW'($urandom);
    slot_loaded[slot] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic push_query(logic [RateW-1:0] rate);
    item_t it;
    it.func  = FuncQuery;
    // Queries carry noise in the unused segment fields.
    it.slot  = IdxW'($urandom);
    it.seg   = '{rate_start: RateW'($urandom), rate_end: RateW'($urandom),
                 start_x: $urandom, start_y: $urandom, start_z: $urandom,
                 end_x: $urandom, end_y: $urandom, end_z: $urandom};
    it.qrate = rate;
    pending_items.push_back(it);
  endtask

  // Waits until every queued item is accepted and every result is back,
  // then lets the block settle before a register write.
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CountW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_count = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [ValW-1:0] got,
                                 logic [ValW-1:0] want);
    $display("Mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // Driver: feeds the pending queue into the input stream on falling edges.
  int unsigned in_gap;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        expected_results.push_back(predict_interp(pending_items.pop_front()));
        in_gap = pick_gap();
      end
      if (in_gap != 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_items[0].func;
        s_axis_tdata  <= InDataW'({pending_items[0].qrate, pending_items[0].seg.end_z,
                          pending_items[0].seg.end_y, pending_items[0].seg.end_x,
                          pending_items[0].seg.start_z, pending_items[0].seg.start_y,
                          pending_items[0].seg.start_x, pending_items[0].seg.rate_end,
                          pending_items[0].seg.rate_start, pending_items[0].slot});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The acceptance is sampled at the rising edge; the driver acts on it at
  // the following falling edge, so the handshake is read before it changes.
  // Receiver back-pressure, with an occasional long hold-off on request.
  int unsigned out_gap;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_request) begin
        hold_request <= 1'b0;
        hold_left    = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // Monitor: checks every result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      lerp_res_t want;
      if (expected_results.size() == 0) begin
        $display("Unexpected result transaction at %0t", $time);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.found)
          report_mismatch("found", ValW'(m_axis_tuser), ValW'(want.found));
        if (m_axis_tdata[31:0] !== want.x) report_mismatch("out_x", m_axis_tdata[31:0], want.x);
        if (m_axis_tdata[63:32] !== want.y)
          report_mismatch("out_y", m_axis_tdata[63:32], want.y);
        if (m_axis_tdata[95:64] !== want.z)
          report_mismatch("out_z", m_axis_tdata[95:64], want.z);
      end
    end
  end

  // Watchdog: counts cycles in which neither stream moves a transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogMax) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Random phase: mix loads of segments with queries, mostly inside the loaded
  // ranges, then pick a search count that only covers loaded slots.
  task automatic random_phase(int unsigned n_items);
    int unsigned max_ok;
    logic [CountW-1:0] cnt;
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        logic [RateW-1:0] rs;
        rs = rand_rate();
        if ($urandom_range(0, 5) == 0) push_load($urandom_range(0, NumSeg - 1), rs, rand_rate());
        else push_load($urandom_range(0, NumSeg - 1), rs,
                       RateW'(rs + $urandom_range(1, 2000)));
      end else if ($urandom_range(0, 3) != 0) begin
        int unsigned s;
        s = $urandom_range(0, NumSeg - 1);
        push_query(shadow_pick(s));
      end else begin
        push_query(rand_rate());
      end
    end
    wait_drained();
    max_ok = 0;
    while (max_ok < NumSeg && slot_loaded[max_ok]) max_ok++;
    cnt = (max_ok == NumSeg && $urandom_range(0, 1)) ? CountW'($urandom_range(NumSeg, 31))
                                                    : CountW'($urandom_range(0, max_ok));
    write_count(cnt);
  endtask

  // A rate for slot s, from the last queued load of it, else near its shadow start.
  function automatic logic [RateW-1:0] shadow_pick(int unsigned s);
    for (int i = pending_items.size() - 1; i >= 0; i--)
      if (pending_items[i].func == FuncLoad && pending_items[i].slot == s) begin
        if (pending_items[i].seg.rate_end > pending_items[i].seg.rate_start)
          return RateW'(pending_items[i].seg.rate_start +
                        $urandom_range(0, pending_items[i].seg.rate_end -
                                          pending_items[i].seg.rate_start - 1));
        return pending_items[i].seg.rate_start;
      end
    return RateW'(shadow_seg[s].rate_start + $urandom_range(0, 3));
  endfunction

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FuncLoad;
    m_axis_tready = 1'b0;
    err_count     = 0;
    idle_cycles   = 0;
    in_gap        = 0;
    out_gap       = 0;
    hold_left     = 0;
    hold_request  = 1'b0;
    in_fire       = 1'b0;
    shadow_count  = '0;
    foreach (shadow_seg[i]) shadow_seg[i] = '0;
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: queries with an empty table miss, then load every slot,
    // including an empty range, an inverted range and full-scale values.
    push_query('0);
    push_query('1);
    for (int unsigned s = 0; s < NumSeg; s++)
      push_load(s, RateW'(s * 16), RateW'(s * 16 + 16));
    push_load(2, 24'd100, 24'd100);
    push_load(3, 24'd500, 24'd200);
    push_load(4, 24'h0, 24'hffffff);
    push_load(15, 24'hfffffe, 24'hffffff);
    wait_drained();
    write_count(5'd31);
    push_query(24'd0);
    push_query(24'd100);
    push_query(24'd300);
    push_query(24'hfffffe);
    push_query(24'hffffff);
    push_query(24'd17);
    wait_drained();
    write_count(5'd0);
    push_query(24'd5);
    wait_drained();
    write_count(5'd16);
    push_query(24'd20);
    push_query(24'd250);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering items.
    hold_request = 1'b1;
    for (int unsigned i = 0; i < 10; i++) push_query(RateW'($urandom_range(0, 300)));
    wait_drained();

    for (int unsigned p = 0; p < 10; p++) random_phase(110);
    wait_drained();
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
